/* design/plcl_pkg.sv */
`default_nettype none

package plcl_pkg;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_EXTRAP = 2'd1;
  localparam logic [1:0] ST_CLAMP  = 2'd2;
  localparam logic [1:0] ST_ZERO_W = 2'd3;

  // Register widths
  localparam int unsigned CNT_W = 7;

  // Divider: 65-bit dividend, 32-bit divisor, one quotient bit per cycle
  localparam int unsigned DVD_W     = 65;
  localparam int unsigned DSR_W     = 32;
  localparam int unsigned DIV_STEPS = 65;
  localparam int unsigned DCNT_W    = 7;

  typedef struct packed {
    logic        command;
    logic [5:0]  entry_index;
    logic [31:0] entry_time_us;
    logic [31:0] entry_iterations;
    logic [31:0] query_time_us;
  } in_item_t;

  typedef struct packed {
    logic [31:0] iterations;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* design/plcl_div.sv */
`default_nettype none

module plcl_div import plcl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output div_stat_t             stat
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;

  logic [DSR_W:0]    rem_sh;
  logic [DSR_W:0]    rem_dif;
  logic              ge;

  // Restoring step: dividend bits shift out at the top, quotient bits shift in below
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    rem_dif = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  assign quotient  = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* design/piecewise_linear_calibration_lookup.sv */
// Channel   Ports                          Moves
// ------    -----------------------------  ------------------------------------
// in        in_valid / in_ready / in_data   load or query item (in_item_t)
// out       out_valid / out_ready / out_data one result per query (out_item_t)
// cfg       cfg_we / cfg_wdata              entries_in_use, written at once
//
// A load writes its entry on the transfer. A query scans from entry 1 up to
// entry n-1 on the table's one read port, then uses the shared 32x32
// multiplier twice and a 65-step divider.
// A zero-width segment skips the multiplier and the divider.
// rst_n is synchronous; the table is not cleared. in_ready is high only
// between queries; a result waiting in the output register holds the next
// query at its final transfer.
`default_nettype none

module piecewise_linear_calibration_lookup import plcl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_RD0      = 4'd3;
  localparam logic [3:0] S_RD1      = 4'd4;
  localparam logic [3:0] S_RD2      = 4'd5;
  localparam logic [3:0] S_DIFF     = 4'd6;
  localparam logic [3:0] S_MUL1     = 4'd7;
  localparam logic [3:0] S_MUL2     = 4'd8;
  localparam logic [3:0] S_SUM      = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_PUSH     = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] entries_r;
  logic [AW-1:0]    n_last_r;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    seg_r;
  logic             found_r;
  logic [31:0]      q_r;
  logic [31:0]      x0_r, x1_r, y0_r, y1_r;
  logic [31:0]      adx_r, ady_r, adq_r;
  logic             ndx_r, ndy_r, ndq_r;
  logic [63:0]      prod_r;
  logic [63:0]      t1_r;
  logic             nres_r;
  logic [31:0]      res_iter_r;
  logic [1:0]       res_stat_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // Table: {time, iterations} per entry, one write and one registered read port
  logic [63:0]      mem [TABLE_DEPTH];
  logic [63:0]      rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [63:0]      wr_word;
  logic [31:0]      wr_idx32;

  logic             in_xfer;
  logic [31:0]      cnt32;
  logic [AW-1:0]    n_last_c;

  logic [32:0]      dx_w, dy_w, dq_w;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic             n1, n2, nsum;
  logic [64:0]      sum65;
  logic [64:0]      dvd_c;

  logic             div_start;
  logic [DVD_W-1:0] quot;
  div_stat_t        div_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Effective count clamped to [2, TABLE_DEPTH], kept as last index
  always_comb begin
    cnt32 = 32'(entries_r);
    if (cnt32 < 32'd2) begin
      n_last_c = AW'(1);
    end else if (cnt32 > 32'(TABLE_DEPTH)) begin
      n_last_c = AW'(TABLE_DEPTH - 1);
    end else begin
      n_last_c = AW'(cnt32 - 32'd1);
    end
  end

  always_comb begin
    wr_idx32 = 32'(in_data.entry_index);
    wr_en    = in_xfer && (in_data.command == CMD_LOAD) && (wr_idx32 < 32'(TABLE_DEPTH));
    wr_addr  = wr_idx32[AW-1:0];
    wr_word  = {(wr_idx32 == 32'd0) ? 32'd0 : in_data.entry_time_us,
                in_data.entry_iterations};
  end

  always_comb begin
    case (state_r)
      S_SCAN_RD: rd_addr = idx_r;
      S_RD0:     rd_addr = seg_r;
      default:   rd_addr = seg_r + AW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Signed differences as sign and magnitude
  always_comb begin
    dx_w = {1'b0, x1_r} - {1'b0, x0_r};
    dy_w = {1'b0, y1_r} - {1'b0, y0_r};
    dq_w = {1'b0, q_r}  - {1'b0, x0_r};
  end

  // Shared multiplier
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = y0_r;
      mul_b = adx_r;
    end else begin
      mul_a = ady_r;
      mul_b = adq_r;
    end
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // Numerator y0*dx + dy*(q-x0) as sign and 65-bit magnitude
  always_comb begin
    n1    = ndx_r && (t1_r != 64'd0);
    n2    = (ndy_r ^ ndq_r) && (prod_r != 64'd0);
    sum65 = {1'b0, t1_r} + {1'b0, prod_r};
    if (n1 == n2) begin
      dvd_c = sum65;
      nsum  = n1;
    end else if (t1_r >= prod_r) begin
      dvd_c = {1'b0, t1_r - prod_r};
      nsum  = n1;
    end else begin
      dvd_c = {1'b0, prod_r - t1_r};
      nsum  = n2;
    end
  end

  assign div_start = (state_r == S_SUM);

  plcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_c),
    .divisor  (adx_r),
    .quotient (quot),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.command == CMD_QUERY)) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if ((rd_data_r[63:32] > q_r) || (idx_r == n_last_r)) begin
          state_nxt = S_RD0;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = (dx_w[31:0] == 32'd0) ? S_PUSH : S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entries_r   <= CNT_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        entries_r <= cfg_wdata;
      end
      if (state_r == S_PUSH && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r      <= in_data.query_time_us;
        n_last_r <= n_last_c;
        idx_r    <= AW'(1);
      end
      S_SCAN_CMP: begin
        if (rd_data_r[63:32] > q_r) begin
          seg_r   <= idx_r - AW'(1);
          found_r <= 1'b1;
        end else if (idx_r == n_last_r) begin
          seg_r   <= n_last_r - AW'(1);
          found_r <= 1'b0;
        end else begin
          idx_r <= idx_r + AW'(1);
        end
      end
      S_RD1: begin
        x0_r <= rd_data_r[63:32];
        y0_r <= rd_data_r[31:0];
      end
      S_RD2: begin
        x1_r <= rd_data_r[63:32];
        y1_r <= rd_data_r[31:0];
      end
      S_DIFF: begin
        ndx_r <= dx_w[32];
        ndy_r <= dy_w[32];
        ndq_r <= dq_w[32];
        adx_r <= dx_w[32] ? (x0_r - x1_r) : dx_w[31:0];
        ady_r <= dy_w[32] ? (y0_r - y1_r) : dy_w[31:0];
        adq_r <= dq_w[32] ? (x0_r - q_r)  : dq_w[31:0];
        // zero-width segment gives the start count
        res_iter_r <= y0_r;
        res_stat_r <= ST_ZERO_W;
      end
      S_MUL1: begin
        prod_r <= mul_p;
      end
      S_MUL2: begin
        t1_r   <= prod_r;
        prod_r <= mul_p;
      end
      S_SUM: begin
        // quotient sign flips when dx is negative
        nres_r <= nsum ^ ndx_r;
      end
      S_DIV: begin
        if (nres_r && (quot != '0)) begin
          res_iter_r <= 32'd0;
          res_stat_r <= ST_CLAMP;
        end else if (quot[DVD_W-1:32] != '0) begin
          res_iter_r <= 32'hFFFF_FFFF;
          res_stat_r <= ST_CLAMP;
        end else begin
          res_iter_r <= quot[31:0];
          res_stat_r <= found_r ? ST_INTERP : ST_EXTRAP;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_data_r.iterations <= res_iter_r;
          out_data_r.status     <= res_stat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_QUERY) |=> (state_r == S_SCAN_RD))
    else $error("accepted query did not start the scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP) |-> (idx_r <= n_last_r) && (idx_r != '0))
    else $error("scan index out of range");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_CLAMP) |->
      (out_data.iterations == 32'd0 || out_data.iterations == 32'hFFFF_FFFF))
    else $error("clamped result not at a rail");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_valid_r && !out_ready) |=> (state_r == S_PUSH))
    else $error("result dropped while output register full");
`endif

endmodule

`default_nettype wire

/* tb/piecewise_linear_calibration_lookup_tb.sv */
`timescale 1ns / 100ps

module piecewise_linear_calibration_lookup_tb;
  import plcl_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned DRAIN_CYCLES = 250;     // margin for the longest query
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned PHASE_ITEMS  = 22;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class calib_scoreboard;
    logic [31:0]      time_mem [DEPTH];
    logic [31:0]      count_mem [DEPTH];
    logic [CNT_W-1:0] entry_count;
    out_item_t        expected_results [$];
    int unsigned      errors;

    function new();
      entry_count = 7'd2;
      errors = 0;
    endfunction

    function void set_entry_count(logic [CNT_W-1:0] value);
      entry_count = value;
    endfunction

    // Exact interpolation: (y0*dx + dy*dq) / dx, truncated toward zero.
    function out_item_t predict_lookup(logic [31:0] q);
      out_item_t          r;
      int unsigned        n, s, i;
      bit                 found;
      logic signed [99:0] x0, x1, y0, y1, qw, dx, num, val;
      n = entry_count;
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      found = 1'b0;
      s = n - 2;
      for (i = 1; i < n; i++) begin
        if (!found && time_mem[i] > q) begin
          s = i - 1;
          found = 1'b1;
        end
      end
      x0 = time_mem[s];
      x1 = time_mem[s + 1];
      y0 = count_mem[s];
      y1 = count_mem[s + 1];
      qw = q;
      dx = x1 - x0;
      if (dx == 0) begin
        r.iterations = count_mem[s];
        r.status = ST_ZERO_W;
        return r;
      end
      num = y0 * dx + (y1 - y0) * (qw - x0);
      val = num / dx;
      if (val < 0) begin
        r.iterations = 32'd0;
        r.status = ST_CLAMP;
      end else if (val > 64'sd4294967295) begin
        r.iterations = 32'hFFFF_FFFF;
        r.status = ST_CLAMP;
      end else begin
        r.iterations = val[31:0];
        r.status = found ? ST_INTERP : ST_EXTRAP;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      if (it.command == CMD_LOAD) begin
        // entry 0 always holds time 0
        time_mem[it.entry_index] = (it.entry_index == 6'd0) ? 32'd0 : it.entry_time_us;
        count_mem[it.entry_index] = it.entry_iterations;
      end else begin
        expected_results = {expected_results, predict_lookup(it.query_time_us)};
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_result(out_item_t r);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", r.iterations, 32'd0);
        return;
      end
      want = expected_results.pop_front();
      if (r.iterations !== want.iterations)
        report_mismatch("iterations", r.iterations, want.iterations);
      if (r.status !== want.status)
        report_mismatch("status", {30'd0, r.status}, {30'd0, want.status});
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  calib_scoreboard  sb;
  idle_mode_t       idle_mode = IDLE_NONE;
  int unsigned      cycle_count = 0;
  logic [31:0]      shadow_time [DEPTH];
  int unsigned      phase_counts [12] = '{2, 3, 0, 5, 8, 64, 1, 127, 4, 65, 16, 6};

  piecewise_linear_calibration_lookup #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit sender_idle();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 80;
      IDLE_BOTH:   return $urandom_range(0, 99) < 33;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 80;
      IDLE_BOTH:     return $urandom_range(0, 99) < 33;
      default:       return 1'b0;
    endcase
  endfunction

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= !receiver_stall();
    end
  end

  function automatic in_item_t make_item(logic cmd, logic [5:0] idx, logic [31:0] t,
                                         logic [31:0] cnt, logic [31:0] q);
    in_item_t it;
    it.command = cmd;
    it.entry_index = idx;
    it.entry_time_us = t;
    it.entry_iterations = cnt;
    it.query_time_us = q;
    return it;
  endfunction

  // valid stays high between back-to-back items; one NBA per edge
  task automatic send_item(in_item_t it);
    if (sender_idle()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (sender_idle());
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic load_entry(logic [5:0] idx, logic [31:0] t, logic [31:0] cnt);
    shadow_time[idx] = (idx == 6'd0) ? 32'd0 : t;
    send_item(make_item(CMD_LOAD, idx, t, cnt, $urandom()));
  endtask

  task automatic query_at(logic [31:0] q);
    send_item(make_item(CMD_QUERY, 6'($urandom_range(0, 63)), $urandom(), $urandom(), q));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_entry_count(value);
  endtask

  // Loads entries 0..n-1 in one of several table shapes.
  task automatic build_table(int unsigned n);
    int unsigned shape, j, idx;
    bit          rev;
    logic [31:0] t, cnt;
    shape = $urandom_range(0, 3);
    rev = ($urandom_range(0, 3) == 0);
    t = 32'd0;
    cnt = $urandom();
    for (j = 0; j < n; j++) begin
      idx = rev ? n - 1 - j : j;
      case (shape)
        0: begin
          t += $urandom_range(1, 1000);
          cnt += $urandom_range(0, 100000);
        end
        1: begin
          t += $urandom_range(1, 32'hFFFF_FFFF / n);
          cnt = $urandom();
        end
        2: begin
          t = $urandom();
          cnt = $urandom();
        end
        default: begin
          t += $urandom_range(0, 2);   // frequent zero-width segments
          cnt = $urandom();
        end
      endcase
      // index 0 gets junk time, the block must store 0 there
      load_entry(6'(idx), (idx == 0) ? $urandom() : t, cnt);
    end
  endtask

  function automatic logic [31:0] pick_query(int unsigned n);
    int unsigned k;
    logic [31:0] lo, hi;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: return shadow_time[k] + $urandom_range(0, 4) - 32'd2;
      3, 4, 5: begin
        lo = shadow_time[k];
        hi = (k < n - 1) ? shadow_time[k + 1] : lo;
        return (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo;
      end
      6:       return shadow_time[n - 1] + $urandom_range(0, 1000000);
      7:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(int unsigned count_value, idle_mode_t mode);
    int unsigned n, r, j;
    write_count(CNT_W'(count_value));
    idle_mode = mode;
    n = count_value;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    build_table(n);
    for (j = 0; j < PHASE_ITEMS; j++) begin
      r = $urandom_range(0, 99);
      if (r < 8 && n <= 16) build_table(n);
      else if (r < 20) load_entry(6'($urandom_range(0, 63)), $urandom(), $urandom());
      else query_at(pick_query(n));
    end
  endtask

  initial begin
    int unsigned p;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two entries at the reset count
    load_entry(6'd0, 32'hFFFF_FFFF, 32'd100);
    load_entry(6'd1, 32'd1000, 32'hFFFF_FFFF);
    query_at(32'd0);
    query_at(32'd500);
    query_at(32'd999);
    query_at(32'd1000);
    query_at(32'hFFFF_FFFF);          // saturates
    load_entry(6'd1, 32'd1000, 32'd0);
    query_at(32'd1005);               // slightly negative, truncates to 0
    query_at(32'hFFFF_FFFF);          // clamps negative
    load_entry(6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query_at(32'hFFFF_FFFF);
    query_at(32'h7FFF_FFFF);
    load_entry(6'd1, 32'd0, 32'd7);   // zero-width segment
    query_at(32'd5);
    query_at(32'd0);
    load_entry(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_entry(6'd62, 32'd0, 32'd0);
    load_entry(6'd0, 32'h1234_5678, 32'd0);
    query_at(32'hFFFF_FFFF);

    for (p = 0; p < 12; p++) run_phase(phase_counts[p], idle_mode_t'(p % 4));

    settle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
